// ===== rtl/hamr_pkg.sv =====
// Shared types, constants and tables for the heading arrow matrix renderer.
package hamr_pkg;

	// Angles are in tenths of a degree.
	localparam logic [11:0] ANGLE_FULL = 12'd3600;
	localparam logic signed [12:0] REL_HALF = 13'sd1800;
	localparam logic signed [12:0] REL_FULL = 13'sd3600;

	// Sector edges, counter-clockwise side inclusive.
	localparam logic signed [12:0] EDGE_NEAR = 13'sd225;
	localparam logic signed [12:0] EDGE_MID = 13'sd675;
	localparam logic signed [12:0] EDGE_WIDE = 13'sd1125;
	localparam logic signed [12:0] EDGE_FAR = 13'sd1575;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TARGET_BEARING = 2'd0,
		REG_COLOUR_THEME   = 2'd1,
		REG_BRIGHTNESS     = 2'd2
	} cfg_reg_t;

	// Colour themes.
	typedef enum logic [1:0] {
		THEME_GREEN = 2'd0,
		THEME_WHITE = 2'd1,
		THEME_GREY  = 2'd2,
		THEME_RED   = 2'd3
	} theme_t;

	// Arrow and background colours in RGB565.
	typedef struct packed {
		logic [15:0] fg;
		logic [15:0] bg;
	} colour_pair_t;

	// Arrow sprites: bit x of row y is set where the pixel belongs to the arrow.
	localparam logic [7:0] SPRITE_ROWS [8][8] = '{
		'{8'h00, 8'h08, 8'h1C, 8'h2A, 8'h08, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h10, 8'h28, 8'h50, 8'h20, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h30, 8'h70, 8'h30, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h20, 8'h18, 8'h30, 8'h40, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h08, 8'h1C, 8'h2A, 8'h08, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h06, 8'h0C, 8'h02, 8'h01, 8'h00},
		'{8'h00, 8'h00, 8'h06, 8'h0E, 8'h06, 8'h00, 8'h00, 8'h00},
		'{8'h01, 8'h02, 8'h0C, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// Bring an angle of 3600 or more back into one turn.
	function automatic logic [11:0] reduce_angle(input logic [11:0] a);
		return (a >= ANGLE_FULL) ? (a - ANGLE_FULL) : a;
	endfunction

	// Pack 5/6/5 components into one RGB565 word.
	function automatic logic [15:0] pack565(input logic [4:0] r, input logic [5:0] g,
		input logic [4:0] b);
		return {r, g, b};
	endfunction

endpackage

// ===== rtl/hamr_sector.sv =====
// Relative angle and direction sector from target bearing and heading.
module hamr_sector (
	input  logic [11:0] target_bearing,
	input  logic [11:0] heading_tenths,
	output logic [2:0]  arrow_sector
);
	import hamr_pkg::*;

	logic [11:0]        tgt_red;
	logic [11:0]        hdg_red;
	logic signed [12:0] rel_raw;
	logic signed [12:0] rel;

	// Difference of the reduced angles, wrapped into (-1800, 1800].
	always_comb begin
		tgt_red = reduce_angle(target_bearing);
		hdg_red = reduce_angle(heading_tenths);
		rel_raw = $signed({1'b0, tgt_red}) - $signed({1'b0, hdg_red});
		if (rel_raw > REL_HALF) begin
			rel = rel_raw - REL_FULL;
		end else if (rel_raw <= -REL_HALF) begin
			rel = rel_raw + REL_FULL;
		end else begin
			rel = rel_raw;
		end
	end

	// Eight 45-degree sectors; an angle on an edge goes counter-clockwise.
	always_comb begin
		if (rel > -EDGE_NEAR && rel <= EDGE_NEAR) begin
			arrow_sector = 3'd0;
		end else if (rel > EDGE_NEAR && rel <= EDGE_MID) begin
			arrow_sector = 3'd1;
		end else if (rel > EDGE_MID && rel <= EDGE_WIDE) begin
			arrow_sector = 3'd2;
		end else if (rel > EDGE_WIDE && rel <= EDGE_FAR) begin
			arrow_sector = 3'd3;
		end else if (rel > EDGE_FAR || rel <= -EDGE_FAR) begin
			arrow_sector = 3'd4;
		end else if (rel <= -EDGE_WIDE) begin
			arrow_sector = 3'd5;
		end else if (rel <= -EDGE_MID) begin
			arrow_sector = 3'd6;
		end else begin
			arrow_sector = 3'd7;
		end
	end

endmodule

// ===== rtl/hamr_palette.sv =====
// Theme colours scaled by the brightness level.
module hamr_palette #(
	parameter int LEVEL_MAX = 10
) (
	input  hamr_pkg::theme_t       theme,
	input  logic [3:0]             brightness,
	output hamr_pkg::colour_pair_t colours
);
	import hamr_pkg::*;

	localparam int LEVELS = 16;

	// Scaled values of the few base components, one entry per brightness code.
	logic [4:0] s31 [LEVELS];
	logic [5:0] s63 [LEVELS];
	logic [4:0] s24 [LEVELS];
	logic [5:0] s48 [LEVELS];

	for (genvar gl = 0; gl < LEVELS; gl++) begin : g_level
		localparam int Lv = (gl > LEVEL_MAX) ? LEVEL_MAX : gl;
		localparam int V31 = (31 * Lv) / LEVEL_MAX;
		localparam int V63 = (63 * Lv) / LEVEL_MAX;
		localparam int V24 = (24 * Lv) / LEVEL_MAX;
		localparam int V48 = (48 * Lv) / LEVEL_MAX;
		assign s31[gl] = 5'(V31);
		assign s63[gl] = 6'(V63);
		assign s24[gl] = 5'(V24);
		assign s48[gl] = 6'(V48);
	end

	// Arrow and background colour for the selected theme.
	always_comb begin
		case (theme)
			THEME_GREEN: begin
				colours.fg = pack565(5'd0, s63[brightness], 5'd0);
				colours.bg = '0;
			end
			THEME_WHITE: begin
				colours.fg = pack565(s31[brightness], s63[brightness], s31[brightness]);
				colours.bg = '0;
			end
			THEME_GREY: begin
				colours.fg = '0;
				colours.bg = pack565(s24[brightness], s48[brightness], s24[brightness]);
			end
			THEME_RED: begin
				colours.fg = pack565(s31[brightness], 6'd0, 5'd0);
				colours.bg = '0;
			end
			default: begin
				colours.fg = '0;
				colours.bg = '0;
			end
		endcase
	end

endmodule

// ===== rtl/heading_arrow_matrix_render.sv =====
// Top level of the heading arrow matrix renderer.
//
// Each input word on the s_axis channel carries a compass heading in tenths of a
// degree. The block turns it into one 8x8 RGB565 frame of 64 pixel words on the
// m_axis channel, rows outer and columns inner, with tlast on the 64th word. The
// arrow points from the heading toward the target bearing set on the cfg port.
// The cfg port is always ready; the user must write it only while no frame is in
// flight, as the block does not enforce this. A heading goes into the frame
// register and each pixel word then through the output register, one pixel word
// per cycle while the receiver keeps tready high. The next heading is taken in
// the cycle the last pixel of the current frame enters the output register, so
// back-to-back frames leave no gap. When the receiver holds tready low, the
// output register and the pixel counter hold, and s_axis_tready stays low until
// the last pixel of the frame enters the output register.
// Reset clears the frame and output valid flags and loads the register defaults:
// bearing 0, white theme, brightness 10.
module heading_arrow_matrix_render #(
	parameter int LEVEL_MAX = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// Heading words.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [11:0] heading_tenths
	// Pixel words.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [2:0] pixel_x, [5:3] pixel_y,
	                                    // [21:6] pixel_colour, [24:22] arrow_sector
	output logic        m_axis_tlast,   // last_pixel
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import hamr_pkg::*;

	localparam logic [5:0] PIX_LAST = 6'd63;

	logic [11:0]  target_q;
	theme_t       theme_q;
	logic [3:0]   bright_q;

	logic [2:0]   sector_new;
	colour_pair_t colours_new;

	logic         frm_valid_s1;
	logic [2:0]   sector_s1;
	colour_pair_t colours_s1;
	logic [5:0]   pix_cnt_q;

	logic         out_valid_q;
	logic [31:0]  out_data_q;
	logic         out_last_q;

	logic         in_accept;
	logic         out_load;
	logic         frm_done;
	logic         pix_on;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 12'd0;
			theme_q  <= THEME_WHITE;
			bright_q <= 4'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_BEARING: target_q <= cfg_data;
				REG_COLOUR_THEME:   theme_q  <= theme_t'(cfg_data[1:0]);
				REG_BRIGHTNESS:     bright_q <= cfg_data[3:0];
				default:            ;
			endcase
		end
	end

	hamr_sector u_sector (
		.target_bearing (target_q),
		.heading_tenths (s_axis_tdata[11:0]),
		.arrow_sector   (sector_new)
	);

	hamr_palette #(
		.LEVEL_MAX (LEVEL_MAX)
	) u_palette (
		.theme      (theme_q),
		.brightness (bright_q),
		.colours    (colours_new)
	);

	// Handshake: a pixel moves into the output register when it is empty or taken.
	assign out_load      = frm_valid_s1 && (!out_valid_q || m_axis_tready);
	assign frm_done      = out_load && (pix_cnt_q == PIX_LAST);
	assign s_axis_tready = !frm_valid_s1 || frm_done;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Frame register: sector, colours and the pixel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_valid_s1 <= 1'b0;
			pix_cnt_q    <= 6'd0;
		end else begin
			if (in_accept) begin
				frm_valid_s1 <= 1'b1;
				pix_cnt_q    <= 6'd0;
			end else if (out_load) begin
				frm_valid_s1 <= !frm_done;
				pix_cnt_q    <= pix_cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sector_s1  <= sector_new;
			colours_s1 <= colours_new;
		end
	end

	// Sprite lookup for the current pixel.
	assign pix_on = SPRITE_ROWS[sector_s1][pix_cnt_q[5:3]][pix_cnt_q[2:0]];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {7'd0, sector_s1, pix_on ? colours_s1.fg : colours_s1.bg,
				pix_cnt_q[5:3], pix_cnt_q[2:0]};
			out_last_q <= (pix_cnt_q == PIX_LAST);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// A new heading starts a fresh frame at its first pixel.
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> frm_valid_s1 && pix_cnt_q == 6'd0)
		else $error("frame did not start at pixel zero");

	// A frame is never dropped before its last pixel has been sent.
	a_frame_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && pix_cnt_q != PIX_LAST |=> frm_valid_s1)
		else $error("frame ended early");

	// The last word of a frame is the bottom right pixel.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_data_q[5:0] == 6'h3F)
		else $error("tlast not on the last pixel");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the heading arrow matrix renderer.
`timescale 1ns / 1ps

module tb_top;
	import hamr_pkg::*;

	localparam int LEVEL_MAX = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASES = 12;
	localparam int HEADINGS_PER_PHASE = 34;

	// Arrow sprites per sector: bit x of row y marks an arrow pixel.
	localparam bit [7:0] ARROW_ROWS [8][8] = '{
		'{8'h00, 8'h08, 8'h1C, 8'h2A, 8'h08, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h10, 8'h28, 8'h50, 8'h20, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h30, 8'h70, 8'h30, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h20, 8'h18, 8'h30, 8'h40, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h08, 8'h1C, 8'h2A, 8'h08, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h06, 8'h0C, 8'h02, 8'h01, 8'h00},
		'{8'h00, 8'h00, 8'h06, 8'h0E, 8'h06, 8'h00, 8'h00, 8'h00},
		'{8'h01, 8'h02, 8'h0C, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// One pixel word as the block should emit it.
	typedef struct packed {
		bit [2:0]  x;
		bit [2:0]  y;
		bit [15:0] colour;
		bit [2:0]  sector;
		bit        last;
	} pixel_t;

	// Predicts the frame drawn for each heading and checks the pixel words against it.
	class arrow_frame_check;
		bit [11:0] bearing;
		theme_t    theme;
		bit [3:0]  level;
		pixel_t    pixels_due [$];
		int        errors;

		function new();
			bearing = 12'd0;
			theme = THEME_WHITE;
			level = 4'd10;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, bit [11:0] value);
			case (idx)
				REG_TARGET_BEARING: bearing = value;
				REG_COLOUR_THEME: theme = theme_t'(value[1:0]);
				REG_BRIGHTNESS: level = value[3:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pixels_due.size();
		endfunction

		// Relative angle wrapped into (-1800,1800], edges belong to the sector before them.
		function bit [2:0] sector_for(bit [11:0] heading);
			int t;
			int h;
			int rel;
			t = bearing;
			h = heading;
			if (t >= 3600) t -= 3600;
			if (h >= 3600) h -= 3600;
			rel = t - h;
			if (rel > 1800) rel -= 3600;
			else if (rel <= -1800) rel += 3600;
			if (rel > 1575 || rel <= -1575) return 3'd4;
			if (rel > 1125) return 3'd3;
			if (rel > 675) return 3'd2;
			if (rel > 225) return 3'd1;
			if (rel > -225) return 3'd0;
			if (rel > -675) return 3'd7;
			if (rel > -1125) return 3'd6;
			return 3'd5;
		endfunction

		// Scale base components by the saturated brightness, truncating.
		function bit [15:0] shade565(int r, int g, int b);
			int lvl;
			bit [4:0] rs;
			bit [5:0] gs;
			bit [4:0] bs;
			lvl = (level > LEVEL_MAX) ? LEVEL_MAX : level;
			rs = 5'(r * lvl / LEVEL_MAX);
			gs = 6'(g * lvl / LEVEL_MAX);
			bs = 5'(b * lvl / LEVEL_MAX);
			return {rs, gs, bs};
		endfunction

		function void note_heading(bit [11:0] heading);
			bit [2:0]  sec;
			bit [15:0] fg;
			bit [15:0] bg;
			pixel_t    p;
			sec = sector_for(heading);
			bg = 16'h0000;
			case (theme)
				THEME_GREEN: fg = shade565(0, 63, 0);
				THEME_WHITE: fg = shade565(31, 63, 31);
				THEME_GREY: begin
					fg = shade565(0, 0, 0);
					bg = shade565(24, 48, 24);
				end
				default: fg = shade565(31, 0, 0);
			endcase
			// Rows outer, columns inner.
			for (int y = 0; y < 8; y++) begin
				for (int x = 0; x < 8; x++) begin
					p.x = 3'(x);
					p.y = 3'(y);
					p.colour = ARROW_ROWS[sec][y][x] ? fg : bg;
					p.sector = sec;
					p.last = (y == 7 && x == 7);
					pixels_due.push_back(p);
				end
			end
		endfunction

		function void check_pixel(bit [31:0] word, bit last);
			pixel_t due;
			if (pixels_due.size() == 0) begin
				$error("pixel word %h arrived with no frame pending", word);
				errors++;
				return;
			end
			due = pixels_due.pop_front();
			if (word[2:0] != due.x) begin
				$error("pixel_x: expected %0d, actual %0d", due.x, word[2:0]);
				errors++;
			end
			if (word[5:3] != due.y) begin
				$error("pixel_y: expected %0d, actual %0d", due.y, word[5:3]);
				errors++;
			end
			if (word[21:6] != due.colour) begin
				$error("pixel_colour: expected %h, actual %h", due.colour, word[21:6]);
				errors++;
			end
			if (word[24:22] != due.sector) begin
				$error("arrow_sector: expected %0d, actual %0d", due.sector, word[24:22]);
				errors++;
			end
			if (last != due.last) begin
				$error("last_pixel: expected %0d, actual %0d", due.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'h0000;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_TARGET_BEARING;
	logic [11:0] cfg_data = 12'h000;

	arrow_frame_check board;
	int pixels_seen = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	heading_arrow_matrix_render #(
		.LEVEL_MAX(LEVEL_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock and a single reset pulse.
	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Offer one heading word and wait until it is taken.
	task automatic send_heading(bit [11:0] heading);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'h0, heading};
		do @(posedge clk); while (!s_axis_tready);
		board.note_heading(heading);
	endtask

	// Sender bursts: keep tvalid up within a burst, drop it for a random gap between bursts.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// Stop offering and wait until every predicted pixel has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back; the block must be idle.
	task automatic write_config(bit [11:0] bearing, theme_t theme, bit [3:0] level);
		cfg_reg_t  idx [3];
		bit [11:0] val [3];
		idx = '{REG_TARGET_BEARING, REG_COLOUR_THEME, REG_BRIGHTNESS};
		val = '{bearing, {10'd0, theme}, {8'd0, level}};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			board.set_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random heading, often placed just around a sector edge for the current bearing.
	function automatic bit [11:0] pick_heading();
		int edges [5];
		int t;
		int rel;
		int h;
		edges = '{225, 675, 1125, 1575, 1800};
		case ($urandom_range(0, 3))
			0: return 12'($urandom_range(0, 4095));
			1: begin
				t = board.bearing;
				if (t >= 3600) t -= 3600;
				rel = edges[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1) == 1) rel = -rel;
				h = ((t - rel) % 3600 + 3600) % 3600;
				if (h < 496 && $urandom_range(0, 1) == 1) h += 3600;
				return h[11:0];
			end
			default: return 12'($urandom_range(0, 3599));
		endcase
	endfunction

	// Stimulus: directed frames first, then random phases with fresh settings.
	initial begin : stimulus
		bit [11:0] edge_headings [15];
		board = new();
		edge_headings = '{12'd1575, 12'd1576, 12'd2025, 12'd2024, 12'd225, 12'd224,
			12'd3375, 12'd3374, 12'd1800, 12'd900, 12'd2700, 12'd1125, 12'd2475,
			12'd675, 12'd2925};
		@(posedge arst_n);
		@(posedge clk);

		// Register defaults after reset, including headings of one full turn or more.
		foreach (edge_headings[i]) begin
			if (i < 5) begin
				pace();
				send_heading(i == 0 ? 12'd0 : i == 1 ? 12'd4095 : i == 2 ? 12'd3600
					: i == 3 ? 12'd225 : 12'd3375);
			end
		end
		drain();

		// Bearing 1800 puts every sector edge at a simple heading.
		write_config(12'd1800, THEME_GREEN, 4'd10);
		foreach (edge_headings[i]) begin
			pace();
			send_heading(edge_headings[i]);
		end
		drain();

		// Brightness zero gives an all black frame.
		write_config(12'd3599, THEME_GREY, 4'd0);
		pace();
		send_heading(12'd0);
		pace();
		send_heading(12'd3599);
		drain();

		// Bearing past a full turn and brightness above the maximum.
		write_config(12'd4095, THEME_RED, 4'd15);
		pace();
		send_heading(12'd495);
		pace();
		send_heading(12'd4095);
		drain();

		write_config(12'd3600, THEME_GREY, 4'd10);
		pace();
		send_heading(12'd0);
		drain();

		// Random phases; each ends with the sender waiting for the last pixel.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_config(12'($urandom_range(0, 4095)), theme_t'($urandom_range(0, 3)),
				4'($urandom_range(0, 15)));
			for (int n = 0; n < HEADINGS_PER_PHASE; n++) begin
				pace();
				send_heading(pick_heading());
			end
			drain();
		end

		if (board.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Receiver: stall patterns that change from time to time, plus one long hold-off.
	initial begin : pixel_sink
		int  mode;
		int  mode_left;
		int  hold_left;
		bit  long_hold_done;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		long_hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			if (!long_hold_done && pixels_seen >= 8000) begin
				long_hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ((mode_left % 7) < 4);
				endcase
			end
		end
	end

	// Check every pixel word taken by the receiver.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_pixel(m_axis_tdata, m_axis_tlast);
			pixels_seen++;
		end
	end

	// Watchdog: end the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no word accepted for %0d cycles", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
rtl/hamr_pkg.sv
rtl/hamr_sector.sv
rtl/hamr_palette.sv
rtl/heading_arrow_matrix_render.sv
tb/tb_top.sv
